// ----- rtl/fractional_synapse_current_update_defines.svh -----
// Assertion macros used by the history and update RTL (fscu_update).
`ifndef FRACTIONAL_SYNAPSE_CURRENT_UPDATE_DEFINES_SVH
`define FRACTIONAL_SYNAPSE_CURRENT_UPDATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/fscu_pkg.sv -----
// Shared constants, types and fixed-point helpers of the synapse current update.
package fscu_pkg;

	localparam int MAX_MEMORY_DEF  = 1024;
	localparam int MAX_NEURONS_DEF = 64;
	localparam int CUR_W           = 32;
	localparam int COEF_W          = 32;
	localparam int WIDE_W          = 72;
	localparam int ACC_W           = 64;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_IDX_W       = 3;
	localparam int ORDER_W         = 32;
	localparam int RATE_W          = 31;
	localparam int LEN_REG_W       = 11;
	localparam int CNT_REG_W       = 7;

	localparam logic [ORDER_W-1:0]   ORDER_RST = 32'h4000_0000;
	localparam logic [RATE_W-1:0]    RATE_RST  = 31'd65536;
	localparam logic [LEN_REG_W-1:0] LEN_RST   = 11'd1024;
	localparam logic [CNT_REG_W-1:0] CNT_RST   = 7'd64;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh4000_0000;

	localparam logic signed [WIDE_W-1:0] SAT_HI = 72'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -72'sd2147483648;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORDER    = 3'd0,
		REG_STEP_POW = 3'd1,
		REG_INV_TAU  = 3'd2,
		REG_MEM_LEN  = 3'd3,
		REG_NEURONS  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic restart;
		logic fill_busy;
	} upd_ctl_t;

	// Divide by 2^sh, round to nearest with ties away from zero.
	function automatic logic signed [WIDE_W-1:0] rnd_shift(
		input logic signed [WIDE_W-1:0] v,
		input int unsigned sh
	);
		logic [WIDE_W-1:0] m;
		logic [WIDE_W-1:0] half;
		half = WIDE_W'(1) << (sh - 1);
		m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		m = (m + half) >> sh;
		return v[WIDE_W-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7fff_ffff;
		end else if (v < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/fractional_synapse_current_update.sv -----
// Top level of the fractional-order synaptic current update block.
// Each input request carries one neuron's spike drive; neuron_count requests in
// neuron order form one time step, and each yields one result with the neuron's
// new current. Each update sums L weighted history terms, where
// L = min(completed steps, memory_length - 1): the history and coefficient
// memories deliver one product term per cycle to the accumulator. A new request
// is taken only after the previous result has been loaded into the output
// register, which may first wait for m_tready. After reset and after every
// write of fractional_order the coefficient memory is refilled by a serial
// divider; while it refills, s_tready stays low.
// Writing memory_length or neuron_count starts a new run from step zero.
module fractional_synapse_current_update import fscu_pkg::*; #(
	parameter int MAX_MEMORY  = MAX_MEMORY_DEF,
	parameter int MAX_NEURONS = MAX_NEURONS_DEF,
	localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1,
	localparam int ODW = ((NW + CUR_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [CUR_W-1:0]      s_tdata,  // spike_value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ODW-1:0]        m_tdata,  // neuron_number, current_value, zero pad
	output logic                  m_tlast
);

	localparam int IW = (MAX_MEMORY > 1) ? $clog2(MAX_MEMORY) : 1;
	localparam int LW = $clog2(MAX_MEMORY + 1);
	localparam int CW = $clog2(MAX_NEURONS + 1);

	logic [ORDER_W-1:0]   order_q;
	logic [RATE_W-1:0]    step_pow_q;
	logic [RATE_W-1:0]    inv_tau_q;
	logic [LEN_REG_W-1:0] mem_len_q;
	logic [CNT_REG_W-1:0] neurons_q;

	logic [LW-1:0]        len_eff;
	logic [CW-1:0]        cnt_eff;
	logic                 fill_req;
	logic                 fill_busy;
	upd_ctl_t             ctl;
	logic [IW-1:0]        coef_addr;
	logic [COEF_W-1:0]    coef_data;
	logic [NW-1:0]        neuron_number;
	logic [CUR_W-1:0]     current_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q    <= ORDER_RST;
			step_pow_q <= RATE_RST;
			inv_tau_q  <= RATE_RST;
			mem_len_q  <= LEN_RST;
			neurons_q  <= CNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORDER:    order_q    <= cfg_data[ORDER_W-1:0];
				REG_STEP_POW: step_pow_q <= cfg_data[RATE_W-1:0];
				REG_INV_TAU:  inv_tau_q  <= cfg_data[RATE_W-1:0];
				REG_MEM_LEN:  mem_len_q  <= cfg_data[LEN_REG_W-1:0];
				REG_NEURONS:  neurons_q  <= cfg_data[CNT_REG_W-1:0];
				default:      order_q    <= order_q;
			endcase
		end
	end

	assign fill_req    = cfg_we && (cfg_index == REG_ORDER);
	assign ctl.restart = cfg_we && ((cfg_index == REG_MEM_LEN) || (cfg_index == REG_NEURONS));
	assign ctl.fill_busy = fill_busy;

	// clamp length and count into the supported range
	assign len_eff = (mem_len_q == '0) ? LW'(1)
		: ((32'(mem_len_q) > 32'(MAX_MEMORY)) ? LW'(MAX_MEMORY) : LW'(mem_len_q));
	assign cnt_eff = (neurons_q == '0) ? CW'(1)
		: ((32'(neurons_q) > 32'(MAX_NEURONS)) ? CW'(MAX_NEURONS) : CW'(neurons_q));

	fscu_coef #(
		.MAX_MEMORY (MAX_MEMORY)
	) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.fill_req (fill_req),
		.order    (order_q),
		.busy     (fill_busy),
		.rd_addr  (coef_addr),
		.rd_data  (coef_data)
	);

	fscu_update #(
		.MAX_MEMORY  (MAX_MEMORY),
		.MAX_NEURONS (MAX_NEURONS)
	) u_update (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.len           (len_eff),
		.cnt           (cnt_eff),
		.inv_tau       (inv_tau_q),
		.step_pow      (step_pow_q),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.spike         (s_tdata),
		.coef_addr     (coef_addr),
		.coef_data     (coef_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.neuron_number (neuron_number),
		.current_value (current_value),
		.step_done     (m_tlast)
	);

	assign m_tdata = ODW'({current_value, neuron_number});

endmodule

// ----- rtl/fscu_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module fscu_divider import fscu_pkg::*; #(
	parameter int DVD_W = 43,
	parameter int DVS_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W-1:0] rem_n;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign rem_n = ge ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// shift the quotient bit in where the dividend bit leaves
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
				rem_q <= rem_n;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- rtl/fscu_coef.sv -----
// Coefficient memory and the sequencer that fills it from the fractional order.
module fscu_coef import fscu_pkg::*; #(
	parameter int MAX_MEMORY = MAX_MEMORY_DEF,
	localparam int IW = (MAX_MEMORY > 1) ? $clog2(MAX_MEMORY) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fill_req,
	input  logic [ORDER_W-1:0] order,
	output logic               busy,
	input  logic [IW-1:0]      rd_addr,
	output logic [COEF_W-1:0]  rd_data
);

	localparam int KW    = IW;
	localparam int MW    = KW + 33;
	localparam int NW1   = MW + 1;
	localparam int DEPTH = 2 ** IW;
	localparam logic [KW-1:0] K_LAST = KW'(MAX_MEMORY - 1);

	typedef enum logic [5:0] {
		F_IDLE  = 6'b000001,
		F_INIT  = 6'b000010,
		F_START = 6'b000100,
		F_WAIT  = 6'b001000,
		F_MUL   = 6'b010000,
		F_WRITE = 6'b100000
	} fill_state_t;

	fill_state_t state_q;

	logic [COEF_W-1:0]        mem [DEPTH];
	logic [KW-1:0]            k_q;
	logic signed [COEF_W-1:0] c_q;
	logic signed [33:0]       factor_q;
	logic signed [65:0]       prod_q;

	logic signed [MW:0]       num;
	logic                     neg;
	logic [MW-1:0]            mag;
	logic [MW-1:0]            dividend;
	logic                     div_done;
	logic [MW-1:0]            quo;
	logic signed [33:0]       factor_n;
	logic signed [COEF_W-1:0] c_next;
	logic                     we;
	logic [IW-1:0]            waddr;
	logic [COEF_W-1:0]        wdata;

	// factor (k-1-alpha)/k, numerator in Q.30
	assign num      = $signed(NW1'({k_q - KW'(1), 30'b0})) - $signed(NW1'(order));
	assign neg      = num[MW];
	assign mag      = neg ? MW'(-num) : MW'(num);
	assign dividend = mag + MW'(k_q >> 1);
	assign factor_n = neg ? -$signed({1'b0, quo[32:0]}) : $signed({1'b0, quo[32:0]});
	assign c_next   = sat32(rnd_shift(WIDE_W'(prod_q), 30));

	fscu_divider #(
		.DVD_W (MW),
		.DVS_W (KW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == F_START),
		.dividend (dividend),
		.divisor  (k_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_INIT;
			k_q      <= '0;
			c_q      <= '0;
			factor_q <= '0;
			prod_q   <= '0;
		end else if (fill_req) begin
			state_q <= F_INIT;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					state_q <= F_IDLE;
				end
				F_INIT: begin
					c_q     <= COEF_ONE;
					k_q     <= KW'(1);
					state_q <= (MAX_MEMORY == 1) ? F_IDLE : F_START;
				end
				F_START: begin
					state_q <= F_WAIT;
				end
				F_WAIT: begin
					if (div_done) begin
						factor_q <= factor_n;
						state_q  <= F_MUL;
					end
				end
				F_MUL: begin
					prod_q  <= c_q * factor_q;
					state_q <= F_WRITE;
				end
				F_WRITE: begin
					c_q <= c_next;
					if (k_q == K_LAST) begin
						state_q <= F_IDLE;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= F_START;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign we    = (state_q == F_INIT) || (state_q == F_WRITE);
	assign waddr = (state_q == F_INIT) ? '0 : k_q;
	assign wdata = (state_q == F_INIT) ? COEF_ONE : c_next;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data <= mem[rd_addr];
	end

	assign busy = (state_q != F_IDLE);

endmodule

// ----- rtl/fscu_update.sv -----
// History memory, multiply-accumulate pipeline and update sequencer.
`include "fractional_synapse_current_update_defines.svh"
module fscu_update import fscu_pkg::*; #(
	parameter int MAX_MEMORY  = MAX_MEMORY_DEF,
	parameter int MAX_NEURONS = MAX_NEURONS_DEF,
	localparam int IW = (MAX_MEMORY > 1) ? $clog2(MAX_MEMORY) : 1,
	localparam int LW = $clog2(MAX_MEMORY + 1),
	localparam int NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1,
	localparam int CW = $clog2(MAX_NEURONS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  upd_ctl_t          ctl,
	input  logic [LW-1:0]     len,
	input  logic [CW-1:0]     cnt,
	input  logic [RATE_W-1:0] inv_tau,
	input  logic [RATE_W-1:0] step_pow,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CUR_W-1:0]  spike,
	output logic [IW-1:0]     coef_addr,
	input  logic [COEF_W-1:0] coef_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [NW-1:0]     neuron_number,
	output logic [CUR_W-1:0]  current_value,
	output logic              step_done
);

	localparam int HDEPTH = 2 ** (NW + IW);

	typedef enum logic [6:0] {
		U_IDLE  = 7'b0000001,
		U_READ  = 7'b0000010,
		U_DRAIN = 7'b0000100,
		U_DIFF  = 7'b0001000,
		U_SCALE = 7'b0010000,
		U_FINAL = 7'b0100000,
		U_OUT   = 7'b1000000
	} upd_state_t;

	upd_state_t state_q;

	logic [CUR_W-1:0]        hist_mem [HDEPTH];
	logic [CUR_W-1:0]        hist_rd_q;

	// run counters
	logic [NW-1:0]           npos_q;
	logic [IW-1:0]           whead_q;
	logic [LW-1:0]           filled_q;

	// per-item working registers
	logic [NW-1:0]           cur_pos_q;
	logic [IW-1:0]           cur_wh_q;
	logic [LW-1:0]           limit_q;
	logic [LW-1:0]           nread_q;
	logic [LW-1:0]           k_q;
	logic [IW-1:0]           idx_q;
	logic signed [CUR_W-1:0] spike_q;
	logic signed [CUR_W-1:0] prev_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [64:0]      p1_q;
	logic signed [63:0]      drive_q;
	logic signed [CUR_W-1:0] res_q;

	// read pipeline
	logic                    rd_s1;
	logic                    en_s1;
	logic                    first_s1;
	logic                    val_s2;
	logic signed [63:0]      prod_s2;

	// output register
	logic                    m_tvalid_q;
	logic [NW-1:0]           m_num_q;
	logic [CUR_W-1:0]        m_cur_q;
	logic                    m_last_q;

	logic                    accept;
	logic                    issue;
	logic [NW-1:0]           pos_eff;
	logic [IW-1:0]           wh_eff;
	logic [IW-1:0]           len_m1;
	logic [LW-1:0]           limit_n;
	logic [LW-1:0]           nread_n;
	logic signed [32:0]      diff;
	logic signed [CUR_W-1:0] rhs;
	logic signed [CUR_W-1:0] cur_n;
	logic signed [ACC_W-1:0] term;
	logic                    last;
	logic                    out_free;
	logic                    hist_we;

	assign s_tready = (state_q == U_IDLE) && !ctl.fill_busy;
	assign accept   = s_tvalid && s_tready;
	assign issue    = (state_q == U_READ);

	assign pos_eff = (CW'(npos_q) >= cnt) ? '0 : npos_q;
	assign wh_eff  = (LW'(whead_q) >= len) ? '0 : whead_q;
	assign len_m1  = IW'(len - LW'(1));
	assign limit_n = (filled_q < LW'(len_m1)) ? filled_q : LW'(len_m1);
	assign nread_n = (filled_q == '0) ? '0 : ((limit_n == '0) ? LW'(1) : limit_n);

	assign diff  = $signed({spike_q[CUR_W-1], spike_q}) - $signed({prev_q[CUR_W-1], prev_q});
	assign rhs   = sat32(rnd_shift(WIDE_W'(p1_q), 16));
	assign cur_n = sat32(rnd_shift(WIDE_W'(drive_q) - WIDE_W'(acc_q), 16));
	assign term  = ACC_W'(rnd_shift(WIDE_W'(prod_s2), 14));

	assign last     = (CW'(cur_pos_q) + CW'(1)) >= cnt;
	assign out_free = !m_tvalid_q || m_tready;
	assign hist_we  = (state_q == U_FINAL);

	assign coef_addr = k_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[{cur_pos_q, cur_wh_q}] <= cur_n;
		end
		hist_rd_q <= hist_mem[{cur_pos_q, idx_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= U_IDLE;
			npos_q     <= '0;
			whead_q    <= '0;
			filled_q   <= '0;
			rd_s1      <= 1'b0;
			en_s1      <= 1'b0;
			first_s1   <= 1'b0;
			val_s2     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_s1    <= issue;
			en_s1    <= issue && (k_q <= limit_q);
			first_s1 <= issue && (k_q == LW'(1));
			val_s2   <= rd_s1 && en_s1;
			if ((state_q == U_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// a new run takes priority over the counter advance
			if (ctl.restart) begin
				npos_q   <= '0;
				whead_q  <= '0;
				filled_q <= '0;
			end else if ((state_q == U_OUT) && out_free) begin
				if (last) begin
					npos_q  <= '0;
					whead_q <= (LW'(cur_wh_q) + LW'(1) == len) ? '0
						: cur_wh_q + IW'(1);
					if (filled_q < len) begin
						filled_q <= filled_q + LW'(1);
					end
				end else begin
					npos_q <= cur_pos_q + NW'(1);
				end
			end
			unique case (state_q)
				U_IDLE: begin
					if (accept) begin
						state_q <= (nread_n == '0) ? U_DRAIN : U_READ;
					end
				end
				U_READ: begin
					if (k_q == nread_q) begin
						state_q <= U_DRAIN;
					end
				end
				U_DRAIN: begin
					// wait for the last product to land in the accumulator
					if (!rd_s1 && !val_s2) begin
						state_q <= U_DIFF;
					end
				end
				U_DIFF: begin
					state_q <= U_SCALE;
				end
				U_SCALE: begin
					state_q <= U_FINAL;
				end
				U_FINAL: begin
					state_q <= U_OUT;
				end
				U_OUT: begin
					if (out_free) begin
						state_q <= U_IDLE;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_pos_q <= pos_eff;
			cur_wh_q  <= wh_eff;
			limit_q   <= limit_n;
			nread_q   <= nread_n;
			k_q       <= LW'(1);
			idx_q     <= (wh_eff == '0) ? len_m1 : wh_eff - IW'(1);
			spike_q   <= $signed(spike);
			prev_q    <= '0;
			acc_q     <= '0;
		end else begin
			if (issue) begin
				k_q   <= k_q + LW'(1);
				idx_q <= (idx_q == '0) ? len_m1 : idx_q - IW'(1);
			end
			if (rd_s1 && first_s1) begin
				prev_q <= $signed(hist_rd_q);
			end
			if (val_s2) begin
				acc_q <= acc_q + term;
			end
		end
		prod_s2 <= $signed(coef_data) * $signed(hist_rd_q);
		if (state_q == U_DIFF) begin
			p1_q <= diff * $signed({1'b0, inv_tau});
		end
		if (state_q == U_SCALE) begin
			drive_q <= rhs * $signed({1'b0, step_pow});
		end
		if (state_q == U_FINAL) begin
			res_q <= cur_n;
		end
		if ((state_q == U_OUT) && out_free) begin
			m_num_q  <= cur_pos_q;
			m_cur_q  <= res_q;
			m_last_q <= last;
		end
	end

	assign m_tvalid      = m_tvalid_q;
	assign neuron_number = m_num_q;
	assign current_value = m_cur_q;
	assign step_done     = m_last_q;

	`FSCU_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != U_IDLE,
		"accepted request did not start an update")
	`FSCU_ASSERT_IMP(a_no_hist_write_in_fill, clk, arst_n, hist_we, !ctl.fill_busy,
		"history written while coefficients refill")
	`FSCU_ASSERT_IMP(a_read_data_in_window, clk, arst_n, rd_s1,
		state_q == U_READ || state_q == U_DRAIN,
		"history read data arrived outside the accumulate window")
	`FSCU_ASSERT_IMP(a_out_load_when_free, clk, arst_n, state_q == U_OUT && !out_free,
		m_tvalid_q, "output stall without a pending result")

endmodule

// ----- tb/tb_fractional_synapse_current_update.sv -----
// Self-checking testbench for the fractional synapse current update block.
module tb_fractional_synapse_current_update import fscu_pkg::*; ();

	localparam int MEM_DEPTH = 1024;
	localparam int NEURONS = 64;
	localparam int OUT_W = 40;
	localparam int STALL_LIMIT = 300000;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [5:0]  neuron;
		logic [31:0] current;
		logic        last;
	} synapse_result_t;

	typedef struct {
		logic [31:0] spike;
		bit          known;
		logic [31:0] current;
	} drive_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [CUR_W-1:0]      s_tdata;  // spike_value
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;  // neuron_number, current_value, zero pad
	logic                  m_tlast;  // step_done

	fractional_synapse_current_update uut (.*);

	// predictor state
	logic [31:0] order_q;
	logic [30:0] step_pow_q;
	logic [30:0] inv_tau_q;
	logic [10:0] mem_len_q;
	logic [6:0]  neuron_cnt_q;
	int          hist_mem [NEURONS*MEM_DEPTH];
	int          coef_mem [MEM_DEPTH];
	int unsigned head_q, filled_q, pos_q;

	synapse_result_t pending_currents[$];
	int  errors;
	int  stall_cycles;
	int  burst_left;
	int  ready_mode;
	int  ready_age;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic longint round_div(longint v, int sh);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void refill_coefficients();
		longint c, num, factor;
		longint unsigned mag;
		c = ONE_Q30;
		coef_mem[0] = int'(c);
		for (int k = 1; k < MEM_DEPTH; k++) begin
			num = longint'(k - 1) * ONE_Q30 - longint'({32'd0, order_q});
			mag = (num < 0) ? longint'(-num) : longint'(num);
			mag = (mag + longint'(k / 2)) / longint'(k);
			factor = (num < 0) ? -longint'(mag) : longint'(mag);
			c = clamp32(round_div(c * factor, 30));
			coef_mem[k] = int'(c);
		end
	endfunction

	function automatic synapse_result_t update_current(logic [31:0] spike_bits);
		synapse_result_t r;
		int unsigned len, cnt, pos, lim, base;
		longint spike, prev, rhs, drive, acc, cur;
		len = (mem_len_q == 0) ? 1 : (mem_len_q > MEM_DEPTH) ? MEM_DEPTH : mem_len_q;
		cnt = (neuron_cnt_q == 0) ? 1 : (neuron_cnt_q > NEURONS) ? NEURONS : neuron_cnt_q;
		pos = (pos_q >= cnt) ? 0 : pos_q;
		if (head_q >= len) head_q = 0;
		spike = longint'($signed(spike_bits));
		base = pos * MEM_DEPTH;
		lim = (filled_q < len - 1) ? filled_q : len - 1;
		prev = 0;
		if (filled_q > 0) prev = hist_mem[base + (head_q + len - 1) % len];
		rhs = clamp32(round_div((spike - prev) * longint'(inv_tau_q), 16));
		drive = rhs * longint'(step_pow_q);
		acc = 0;
		for (int unsigned k = 1; k <= lim; k++)
			acc += round_div(longint'(coef_mem[k])
				* longint'(hist_mem[base + (head_q + len - k) % len]), 14);
		cur = clamp32(round_div(drive - acc, 16));
		hist_mem[base + head_q] = int'(cur);
		r.neuron = pos[5:0];
		r.current = cur[31:0];
		r.last = (pos + 1 >= cnt);
		if (r.last) begin
			pos_q = 0;
			head_q = (head_q + 1) % len;
			if (filled_q < len) filled_q++;
		end else begin
			pos_q = pos + 1;
		end
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_currents.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ORDER: begin
				order_q = val;
				refill_coefficients();
			end
			REG_STEP_POW: step_pow_q = val[30:0];
			REG_INV_TAU: inv_tau_q = val[30:0];
			REG_MEM_LEN, REG_NEURONS: begin
				if (idx == REG_MEM_LEN) mem_len_q = val[10:0];
				else neuron_cnt_q = val[6:0];
				head_q = 0;
				filled_q = 0;
				pos_q = 0;
			end
			default: ;
		endcase
	endtask

	task automatic send_spike(logic [31:0] spike, bit known, logic [31:0] known_cur);
		synapse_result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		// hold off until the block has drained everything
		if (($urandom_range(0, 60) == 0) && (pending_currents.size() != 0)) begin
			s_tvalid <= 1'b0;
			while (pending_currents.size() != 0) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= spike;
		do @(posedge clk); while (!s_tready);
		r = update_current(spike);
		if (known) r.current = known_cur;
		pending_currents.push_back(r);
		burst_left--;
	endtask

	function automatic logic [31:0] random_spike();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1, 2: return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($urandom_range(0, 2)) - 32'd1;
		endcase
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) send_spike(random_spike(), 1'b0, '0);
		s_tvalid <= 1'b0;
		burst_left = 0;
		wait_drained();
	endtask

	task automatic set_phase(logic [31:0] ord, logic [31:0] sp, logic [31:0] it,
			logic [31:0] ln, logic [31:0] cn);
		write_reg(REG_ORDER, ord);
		write_reg(REG_STEP_POW, sp);
		write_reg(REG_INV_TAU, it);
		write_reg(REG_MEM_LEN, ln);
		write_reg(REG_NEURONS, cn);
	endtask

	// receiver stall pattern, mode chosen at random whenever ready_age wraps to zero
	always @(posedge clk) begin
		if (ready_age == 0) ready_mode <= $urandom_range(0, 3);
		ready_age <= (ready_age + 1) % 64;
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= (ready_age[3:0] < 4'd10);
		endcase
	end

	always @(posedge clk) begin
		synapse_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_currents.size() == 0) begin
				$display("%0t: unexpected result neuron %0d current %h", $time,
					m_tdata[5:0], m_tdata[37:6]);
				errors++;
			end else begin
				e = pending_currents.pop_front();
				if (m_tdata[5:0] !== e.neuron) begin
					$display("%0t: neuron_number expected %0d actual %0d", $time,
						e.neuron, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[37:6] !== e.current) begin
					$display("%0t: current_value expected %h actual %h", $time,
						e.current, m_tdata[37:6]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: step_done expected %b actual %b", $time, e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	drive_row_t directed [20];

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		stall_cycles = 0;
		burst_left = 0;
		ready_mode = 0;
		ready_age = 0;
		order_q = ORDER_RST;
		step_pow_q = RATE_RST;
		inv_tau_q = RATE_RST;
		mem_len_q = LEN_RST;
		neuron_cnt_q = CNT_RST;
		head_q = 0;
		filled_q = 0;
		pos_q = 0;
		foreach (hist_mem[i]) hist_mem[i] = 0;
		refill_coefficients();

		// first step after reset: no history, unit gains, current equals drive
		directed[0]  = '{32'h0000_0000, 1, 32'h0000_0000};
		directed[1]  = '{32'h7FFF_FFFF, 1, 32'h7FFF_FFFF};
		directed[2]  = '{32'h8000_0000, 1, 32'h8000_0000};
		directed[3]  = '{32'hFFFF_FFFF, 1, 32'hFFFF_FFFF};
		directed[4]  = '{32'h0000_0001, 1, 32'h0000_0001};
		directed[5]  = '{32'h0001_0000, 1, 32'h0001_0000};
		directed[6]  = '{32'hFFFF_0000, 1, 32'hFFFF_0000};
		directed[7]  = '{32'h5555_5555, 1, 32'h5555_5555};
		directed[8]  = '{32'hAAAA_AAAA, 1, 32'hAAAA_AAAA};
		directed[9]  = '{32'h0000_8000, 1, 32'h0000_8000};
		for (int i = 10; i < 20; i++) directed[i] = '{random_spike(), 0, '0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_spike(directed[i].spike, directed[i].known,
			directed[i].current);
		s_tvalid <= 1'b0;
		burst_left = 0;
		wait_drained();

		// out-of-list index must be ignored
		write_reg(cfg_reg_t'(REG_UNUSED), $urandom);
		set_phase(32'h2000_0000, 32'h0001_0000, 32'h0000_8000, 16, 4);
		run_random(100);
		set_phase(32'h0000_0000, 32'h0000_C000, 32'h0001_0000, 1, 1);
		run_random(60);
		// length above max, count zero, order 2.0, max gains
		set_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2047, 0);
		run_random(60);
		// order above 2.0, length zero, count above max
		set_phase(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 0, 127);
		run_random(80);
		write_reg(REG_STEP_POW, 32'h0001_8000);
		write_reg(REG_MEM_LEN, 1024);
		write_reg(REG_NEURONS, 64);
		run_random(70);
		for (int p = 0; p < 3; p++) begin
			set_phase($urandom_range(0, 32'h8000_0000), $urandom_range(0, 32'h20000),
				$urandom_range(0, 32'h20000), $urandom_range(2, 40), $urandom_range(1, 8));
			run_random(64);
		end

		while (pending_currents.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fscu_pkg.sv
rtl/fscu_divider.sv
rtl/fscu_coef.sv
rtl/fscu_update.sv
rtl/fractional_synapse_current_update.sv
tb/tb_fractional_synapse_current_update.sv
